// ----- rtl/qbv_pkg.sv -----
// Shared types, constants and rounding helpers for the shortest-arc quaternion block.
// Used by every module under rtl; depends on nothing else.
package qbv_pkg;

    // port field widths
    localparam int COMP_W = 16;
    localparam int FRAC_W = 14;
    localparam int QUAT_W = FRAC_W + 2;

    // internal fixed point: unit vectors, cosine and axis are Q30
    localparam int QB     = 30;
    localparam int VEC_W  = 32;
    localparam int PROD_W = 64;

    // pipelined square root: 64-bit radicand, one root bit per stage
    localparam int SQ_RAD_W  = 64;
    localparam int SQ_ROOT_W = SQ_RAD_W / 2;
    localparam int SQ_STAGES = SQ_ROOT_W;

    // pipelined divider: (magnitude << QB) + root/2 over the root
    localparam int DVD_W = QB + VEC_W;
    localparam int DSR_W = SQ_ROOT_W;
    localparam int QUO_W = QB + 1;

    // normalizer: magnitude/square, sum, root, dividend, divide, sign
    localparam int NORM_LAT = 4 + SQ_STAGES + QUO_W;
    localparam int HALF_LAT = NORM_LAT - SQ_STAGES;

    localparam logic signed [VEC_W-1:0] ONE_Q     = VEC_W'(64'd1 << QB);
    localparam logic signed [VEC_W-1:0] NEG_ONE_Q = -ONE_Q;
    // cos below -0.999 takes the fallback axis
    localparam logic signed [VEC_W-1:0] OPP_LIMIT = NEG_ONE_Q + 32'sd1073742;
    // 0.01 in Q30: axis too short for the z-hat cross
    localparam logic signed [33:0] SMALL_AXIS = 34'sd10737418;
    localparam logic signed [QUAT_W-1:0] OUT_ONE = QUAT_W'(1) << FRAC_W;

    typedef logic signed [VEC_W-1:0] t_vcomp;
    typedef t_vcomp [2:0] t_vec3;

    typedef struct packed {
        logic signed [COMP_W-1:0] first_x;
        logic signed [COMP_W-1:0] first_y;
        logic signed [COMP_W-1:0] first_z;
        logic signed [COMP_W-1:0] second_x;
        logic signed [COMP_W-1:0] second_y;
        logic signed [COMP_W-1:0] second_z;
    } t_in;

    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic                     opposite_case;
        logic                     degenerate;
    } t_out;

    // Q60 -> Q30, round half away from zero
    function automatic logic signed [33:0] rnd_q30(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] r;
        m = v[PROD_W-1] ? (~v + PROD_W'(1)) : v;
        r = (m + (PROD_W'(1) << (QB - 1))) >> QB;
        return v[PROD_W-1] ? -$signed(34'(r)) : $signed(34'(r));
    endfunction

    // Q30 -> output format, round half away from zero, saturate at +/-1
    function automatic logic signed [QUAT_W-1:0] to_out(input logic signed [VEC_W-1:0] q);
        logic [VEC_W-1:0] m;
        logic [VEC_W-1:0] r;
        logic [VEC_W-1:0] lim;
        m   = q[VEC_W-1] ? (~q + VEC_W'(1)) : q;
        r   = (m + (VEC_W'(1) << (QB - FRAC_W - 1))) >> (QB - FRAC_W);
        lim = VEC_W'(1) << FRAC_W;
        if (r > lim) begin
            r = lim;
        end
        return q[VEC_W-1] ? -$signed(QUAT_W'(r)) : $signed(QUAT_W'(r));
    endfunction

endpackage

// ----- rtl/quaternion_between_vectors.sv -----
// Top level: shortest-arc rotation quaternion between two integer 3-vectors.
// Depends on qbv_pkg, qbv_norm and qbv_sqrt.
//
//  channel  direction  handshake            payload
//  input    in         i_valid / o_ready    i_data  (qbv_pkg::t_in)
//  output   out        o_valid / i_ready    o_data  (qbv_pkg::t_out)
//
// One transfer in per cycle while the skid entry is empty. Data passes two normalizers
// of 67 stages each, set by the 32-stage root and 31-stage divider inside them.
// The whole pipeline advances together; an output register plus a skid entry keep
// o_ready registered and let input transfers continue while a result waits.
// The pipeline holds only while the skid entry is full.
// Reset (synchronous, active low) clears valid bits and their side flags only.
module quaternion_between_vectors (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qbv_pkg::t_in   i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output qbv_pkg::t_out  o_data
);
    typedef struct packed {
        logic vld;
        logic opp;
        logic deg;
    } t_side;

    logic                 w_en;
    qbv_pkg::t_in         r_in;
    logic                 r_in_vld;
    qbv_pkg::t_vec3       w_va;
    qbv_pkg::t_vec3       w_vb;
    qbv_pkg::t_vec3       w_u;
    qbv_pkg::t_vec3       w_v;
    logic                 w_zu;
    logic                 w_zv;
    logic                 r_v1 [qbv_pkg::NORM_LAT];

    // stage 1: products
    logic signed [qbv_pkg::PROD_W-1:0] r1_dot [3];
    logic signed [qbv_pkg::PROD_W-1:0] r1_cp  [6];
    logic signed [qbv_pkg::PROD_W-1:0] r1_sq  [2];
    qbv_pkg::t_vec3       r1_u;
    logic                 r1_deg;
    logic                 r1_vld;
    // stage 2: sums
    logic signed [qbv_pkg::PROD_W-1:0] r2_dot;
    logic signed [qbv_pkg::PROD_W-1:0] r2_cx [3];
    logic signed [qbv_pkg::PROD_W-1:0] r2_sm;
    qbv_pkg::t_vec3       r2_u;
    logic                 r2_deg;
    logic                 r2_vld;
    // stage 3: rounding
    logic signed [33:0]   w_c_r;
    logic signed [qbv_pkg::VEC_W-1:0] r3_c;
    qbv_pkg::t_vec3       r3_cr;
    logic                 r3_small;
    qbv_pkg::t_vec3       r3_u;
    logic                 r3_deg;
    logic                 r3_vld;
    // stage 4: case select and half-angle radicands
    logic                 w_opp;
    qbv_pkg::t_vec3       r4_cr;
    logic [qbv_pkg::SQ_RAD_W-1:0] r4_rad_s;
    logic [qbv_pkg::SQ_RAD_W-1:0] r4_rad_w;
    t_side                r4_side;
    t_side                r_v2 [qbv_pkg::NORM_LAT];
    // half-angle roots
    logic [qbv_pkg::SQ_ROOT_W-1:0] w_rs;
    logic [qbv_pkg::SQ_ROOT_W-1:0] w_rw;
    logic [qbv_pkg::SQ_RAD_W-1:0]  w_es;
    logic [qbv_pkg::SQ_RAD_W-1:0]  w_ew;
    logic [qbv_pkg::SQ_ROOT_W-1:0] r_hs [qbv_pkg::HALF_LAT];
    logic [qbv_pkg::SQ_ROOT_W-1:0] r_hw [qbv_pkg::HALF_LAT];
    qbv_pkg::t_vec3       w_ax;
    logic                 w_zax;
    t_side                w_s5;
    // stage 6..8
    logic signed [qbv_pkg::PROD_W-1:0] r6_prod [3];
    qbv_pkg::t_vec3       r6_ax;
    logic [qbv_pkg::SQ_ROOT_W-1:0] r6_w;
    t_side                r6_side;
    logic signed [qbv_pkg::VEC_W-1:0] r7_q [4];
    t_side                r7_side;
    qbv_pkg::t_out        r8_data;
    logic                 r8_vld;
    // output register and skid entry
    qbv_pkg::t_out        r_out;
    logic                 r_out_vld;
    qbv_pkg::t_out        r_skid;
    logic                 r_skid_vld;

    assign w_en    = !r_skid_vld;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_en) begin
            r_in_vld <= i_valid;
        end
    end

    assign w_va[0] = qbv_pkg::VEC_W'(r_in.first_x);
    assign w_va[1] = qbv_pkg::VEC_W'(r_in.first_y);
    assign w_va[2] = qbv_pkg::VEC_W'(r_in.first_z);
    assign w_vb[0] = qbv_pkg::VEC_W'(r_in.second_x);
    assign w_vb[1] = qbv_pkg::VEC_W'(r_in.second_y);
    assign w_vb[2] = qbv_pkg::VEC_W'(r_in.second_z);

    qbv_norm u_norm_a (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (w_va),
        .o_unit (w_u),
        .o_zero (w_zu)
    );

    qbv_norm u_norm_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (w_vb),
        .o_unit (w_v),
        .o_zero (w_zv)
    );

    // valid and side flags across the normalizers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < qbv_pkg::NORM_LAT; s++) begin
                r_v1[s] <= 1'b0;
                r_v2[s] <= '0;
            end
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r4_side   <= '0;
            r6_side   <= '0;
            r7_side   <= '0;
            r8_vld    <= 1'b0;
        end else if (w_en) begin
            r_v1[0] <= r_in_vld;
            r_v2[0] <= r4_side;
            for (int s = 1; s < qbv_pkg::NORM_LAT; s++) begin
                r_v1[s] <= r_v1[s-1];
                r_v2[s] <= r_v2[s-1];
            end
            r1_vld  <= r_v1[qbv_pkg::NORM_LAT-1];
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r4_side <= '{vld: r3_vld, opp: w_opp, deg: r3_deg};
            r6_side <= w_s5;
            r7_side <= r6_side;
            r8_vld  <= r7_side.vld;
        end
    end

    // stage 1: dot, cross and fallback-test products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r1_dot[l] <= w_u[l] * w_v[l];
            end
            r1_cp[0] <= w_u[1] * w_v[2];
            r1_cp[1] <= w_u[2] * w_v[1];
            r1_cp[2] <= w_u[2] * w_v[0];
            r1_cp[3] <= w_u[0] * w_v[2];
            r1_cp[4] <= w_u[0] * w_v[1];
            r1_cp[5] <= w_u[1] * w_v[0];
            r1_sq[0] <= w_u[0] * w_u[0];
            r1_sq[1] <= w_u[1] * w_u[1];
            r1_u     <= w_u;
            r1_deg   <= w_zu | w_zv;
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_dot   <= r1_dot[0] + r1_dot[1] + r1_dot[2];
            r2_cx[0] <= r1_cp[0] - r1_cp[1];
            r2_cx[1] <= r1_cp[2] - r1_cp[3];
            r2_cx[2] <= r1_cp[4] - r1_cp[5];
            r2_sm    <= r1_sq[0] + r1_sq[1];
            r2_u     <= r1_u;
            r2_deg   <= r1_deg;
        end
    end

    // stage 3: back to Q30, cosine clamped to [-1, 1]
    assign w_c_r = qbv_pkg::rnd_q30(r2_dot);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_c_r > qbv_pkg::ONE_Q) begin
                r3_c <= qbv_pkg::ONE_Q;
            end else if (w_c_r < qbv_pkg::NEG_ONE_Q) begin
                r3_c <= qbv_pkg::NEG_ONE_Q;
            end else begin
                r3_c <= qbv_pkg::VEC_W'(w_c_r);
            end
            for (int l = 0; l < 3; l++) begin
                r3_cr[l] <= qbv_pkg::VEC_W'(qbv_pkg::rnd_q30(r2_cx[l]));
            end
            r3_small <= qbv_pkg::rnd_q30(r2_sm) < qbv_pkg::SMALL_AXIS;
            r3_u     <= r2_u;
            r3_deg   <= r2_deg;
        end
    end

    // stage 4: near-opposite vectors rotate about an axis normal to the first
    assign w_opp = !r3_deg && (r3_c < qbv_pkg::OPP_LIMIT);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (!w_opp) begin
                r4_cr <= r3_cr;
            end else if (r3_small) begin
                r4_cr[0] <= '0;
                r4_cr[1] <= -r3_u[2];
                r4_cr[2] <= r3_u[1];
            end else begin
                r4_cr[0] <= -r3_u[1];
                r4_cr[1] <= r3_u[0];
                r4_cr[2] <= '0;
            end
            r4_rad_s <= qbv_pkg::SQ_RAD_W'((qbv_pkg::PROD_W'(qbv_pkg::ONE_Q)
                        - qbv_pkg::PROD_W'(r3_c)) << (qbv_pkg::QB - 1));
            r4_rad_w <= qbv_pkg::SQ_RAD_W'((qbv_pkg::PROD_W'(qbv_pkg::ONE_Q)
                        + qbv_pkg::PROD_W'(r3_c)) << (qbv_pkg::QB - 1));
        end
    end

    qbv_norm u_norm_ax (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_vec  (r4_cr),
        .o_unit (w_ax),
        .o_zero (w_zax)
    );

    qbv_sqrt u_sqrt_s (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r4_rad_s),
        .o_root (w_rs),
        .o_rem  (w_es)
    );

    qbv_sqrt u_sqrt_w (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r4_rad_w),
        .o_root (w_rw),
        .o_rem  (w_ew)
    );

    // nearest root: bump when the remainder exceeds the floor root
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hs[0] <= w_rs + qbv_pkg::SQ_ROOT_W'(w_es > qbv_pkg::SQ_RAD_W'(w_rs));
            r_hw[0] <= w_rw + qbv_pkg::SQ_ROOT_W'(w_ew > qbv_pkg::SQ_RAD_W'(w_rw));
            for (int s = 1; s < qbv_pkg::HALF_LAT; s++) begin
                r_hs[s] <= r_hs[s-1];
                r_hw[s] <= r_hw[s-1];
            end
        end
    end

    // parallel vectors leave no axis
    always_comb begin
        w_s5     = r_v2[qbv_pkg::NORM_LAT-1];
        w_s5.deg = w_s5.deg | (!w_s5.opp && w_zax);
    end

    // stage 6: axis times sin of half angle
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < 3; l++) begin
                r6_prod[l] <= w_ax[l]
                    * $signed({1'b0, r_hs[qbv_pkg::HALF_LAT-1][qbv_pkg::VEC_W-2:0]});
            end
            r6_ax <= w_ax;
            r6_w  <= r_hw[qbv_pkg::HALF_LAT-1];
        end
    end

    // stage 7: pick identity, fallback axis or rotation
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r6_side.deg) begin
                r7_q[0] <= qbv_pkg::ONE_Q;
                for (int l = 0; l < 3; l++) begin
                    r7_q[l+1] <= '0;
                end
            end else if (r6_side.opp) begin
                r7_q[0] <= '0;
                for (int l = 0; l < 3; l++) begin
                    r7_q[l+1] <= r6_ax[l];
                end
            end else begin
                r7_q[0] <= $signed(r6_w);
                for (int l = 0; l < 3; l++) begin
                    r7_q[l+1] <= qbv_pkg::VEC_W'(qbv_pkg::rnd_q30(r6_prod[l]));
                end
            end
        end
    end

    // stage 8: output format
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_data.quat_w        <= qbv_pkg::to_out(r7_q[0]);
            r8_data.quat_x        <= qbv_pkg::to_out(r7_q[1]);
            r8_data.quat_y        <= qbv_pkg::to_out(r7_q[2]);
            r8_data.quat_z        <= qbv_pkg::to_out(r7_q[3]);
            r8_data.opposite_case <= r7_side.opp;
            r8_data.degenerate    <= r7_side.deg;
        end
    end

    // output register with one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (i_ready) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (r8_vld) begin
            if (!r_out_vld || i_ready) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (r8_vld) begin
            if (!r_out_vld || i_ready) begin
                r_out <= r8_data;
            end else begin
                r_skid <= r8_data;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry full while output register empty");

    a_ident_on_degen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.degenerate) |->
        (o_data.quat_w == qbv_pkg::OUT_ONE && o_data.quat_x == '0 &&
         o_data.quat_y == '0 && o_data.quat_z == '0 && !o_data.opposite_case))
        else $error("degenerate result is not the identity");

    a_opp_zero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.opposite_case) |-> (o_data.quat_w == '0))
        else $error("opposite case with nonzero scalar part");
`endif

endmodule

// ----- rtl/qbv_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, floor root plus remainder.
// Depends on qbv_pkg for widths.
module qbv_sqrt (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [qbv_pkg::SQ_RAD_W-1:0]   i_rad,
    output logic [qbv_pkg::SQ_ROOT_W-1:0]  o_root,
    output logic [qbv_pkg::SQ_RAD_W-1:0]   o_rem
);
    localparam int TW = qbv_pkg::SQ_RAD_W + 2;

    logic [qbv_pkg::SQ_RAD_W-1:0]  r_rem  [qbv_pkg::SQ_STAGES];
    logic [qbv_pkg::SQ_ROOT_W-1:0] r_root [qbv_pkg::SQ_STAGES];
    logic [qbv_pkg::SQ_RAD_W-1:0]  n_rem  [qbv_pkg::SQ_STAGES];
    logic [qbv_pkg::SQ_ROOT_W-1:0] n_root [qbv_pkg::SQ_STAGES];

    for (genvar g = 0; g < qbv_pkg::SQ_STAGES; g++) begin : g_stage
        localparam int K = qbv_pkg::SQ_STAGES - 1 - g;
        logic [qbv_pkg::SQ_RAD_W-1:0]  w_rem_in;
        logic [qbv_pkg::SQ_ROOT_W-1:0] w_root_in;
        logic [TW-1:0]                 w_trial;
        logic                          w_fit;

        if (g == 0) begin : g_head
            assign w_rem_in  = i_rad;
            assign w_root_in = '0;
        end else begin : g_body
            assign w_rem_in  = r_rem[g-1];
            assign w_root_in = r_root[g-1];
        end

        // (r + 2^K)^2 - r^2, root holds only bits above K
        assign w_trial   = (TW'(w_root_in) << (K + 1)) + (TW'(1) << (2 * K));
        assign w_fit     = TW'(w_rem_in) >= w_trial;
        assign n_rem[g]  = w_fit ? qbv_pkg::SQ_RAD_W'(TW'(w_rem_in) - w_trial) : w_rem_in;
        assign n_root[g] = w_fit ? (w_root_in | (qbv_pkg::SQ_ROOT_W'(1) << K)) : w_root_in;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < qbv_pkg::SQ_STAGES; s++) begin
                r_rem[s]  <= n_rem[s];
                r_root[s] <= n_root[s];
            end
        end
    end

    assign o_root = r_root[qbv_pkg::SQ_STAGES-1];
    assign o_rem  = r_rem[qbv_pkg::SQ_STAGES-1];

endmodule

// ----- rtl/qbv_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, divisor carried along.
// Depends on qbv_pkg for widths.
module qbv_div (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [qbv_pkg::DVD_W-1:0]   i_dvd,
    input  logic [qbv_pkg::DSR_W-1:0]   i_dsr,
    output logic [qbv_pkg::QUO_W-1:0]   o_quo
);
    localparam int CW = qbv_pkg::DVD_W + 1;

    logic [qbv_pkg::DVD_W-1:0] r_rem [qbv_pkg::QUO_W];
    logic [qbv_pkg::QUO_W-1:0] r_quo [qbv_pkg::QUO_W];
    logic [qbv_pkg::DSR_W-1:0] r_dsr [qbv_pkg::QUO_W];
    logic [qbv_pkg::DVD_W-1:0] n_rem [qbv_pkg::QUO_W];
    logic [qbv_pkg::QUO_W-1:0] n_quo [qbv_pkg::QUO_W];
    logic [qbv_pkg::DSR_W-1:0] n_dsr [qbv_pkg::QUO_W];

    for (genvar g = 0; g < qbv_pkg::QUO_W; g++) begin : g_stage
        localparam int K = qbv_pkg::QUO_W - 1 - g;
        logic [qbv_pkg::DVD_W-1:0] w_rem_in;
        logic [qbv_pkg::QUO_W-1:0] w_quo_in;
        logic [qbv_pkg::DSR_W-1:0] w_dsr_in;
        logic [CW-1:0]             w_sub;
        logic                      w_fit;

        if (g == 0) begin : g_head
            assign w_rem_in = i_dvd;
            assign w_quo_in = '0;
            assign w_dsr_in = i_dsr;
        end else begin : g_body
            assign w_rem_in = r_rem[g-1];
            assign w_quo_in = r_quo[g-1];
            assign w_dsr_in = r_dsr[g-1];
        end

        assign w_sub    = CW'(w_dsr_in) << K;
        assign w_fit    = CW'(w_rem_in) >= w_sub;
        assign n_rem[g] = w_fit ? qbv_pkg::DVD_W'(CW'(w_rem_in) - w_sub) : w_rem_in;
        assign n_quo[g] = w_fit ? (w_quo_in | (qbv_pkg::QUO_W'(1) << K)) : w_quo_in;
        assign n_dsr[g] = w_dsr_in;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < qbv_pkg::QUO_W; s++) begin
                r_rem[s] <= n_rem[s];
                r_quo[s] <= n_quo[s];
                r_dsr[s] <= n_dsr[s];
            end
        end
    end

    assign o_quo = r_quo[qbv_pkg::QUO_W-1];

endmodule

// ----- rtl/qbv_norm.sv -----
// Three-lane vector normalizer to Q30: squares, shared root, one divider per lane.
// Depends on qbv_pkg, qbv_sqrt and qbv_div.
module qbv_norm (
    input  logic           i_clk,
    input  logic           i_en,
    input  qbv_pkg::t_vec3 i_vec,
    output qbv_pkg::t_vec3 o_unit,
    output logic           o_zero
);
    localparam int MLEN = qbv_pkg::SQ_STAGES + 1;
    localparam int SLEN = qbv_pkg::QUO_W + 1;

    logic [2:0][qbv_pkg::VEC_W-1:0]   w_abs;
    logic [2:0][qbv_pkg::VEC_W-1:0]   r_m1;
    logic [2:0]                       r_neg1;
    logic [2:0][qbv_pkg::PROD_W-1:0]  r_sq;
    logic [qbv_pkg::SQ_RAD_W-1:0]     r_sum;
    logic [2:0][qbv_pkg::VEC_W-1:0]   r_mline [MLEN];
    logic [2:0]                       r_nline [MLEN];
    logic [qbv_pkg::SQ_ROOT_W-1:0]    w_root;
    logic [2:0][qbv_pkg::DVD_W-1:0]   r_dvd;
    logic [qbv_pkg::DSR_W-1:0]        r_dn;
    logic [3:0]                       r_sline [SLEN];
    logic [qbv_pkg::QUO_W-1:0]        w_quo [3];
    logic [3:0]                       w_sgn;
    qbv_pkg::t_vec3                   r_unit;
    logic                             r_zero;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_abs[l] = i_vec[l][qbv_pkg::VEC_W-1] ? (~i_vec[l] + qbv_pkg::VEC_W'(1))
                                                  : i_vec[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_m1[l]   <= w_abs[l];
                r_neg1[l] <= i_vec[l][qbv_pkg::VEC_W-1];
                r_sq[l]   <= w_abs[l] * w_abs[l];
            end
            r_sum <= r_sq[0] + r_sq[1] + r_sq[2];
            // magnitudes and signs ride alongside the root
            r_mline[0] <= r_m1;
            r_nline[0] <= r_neg1;
            for (int s = 1; s < MLEN; s++) begin
                r_mline[s] <= r_mline[s-1];
                r_nline[s] <= r_nline[s-1];
            end
        end
    end

    qbv_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_rad  (r_sum),
        .o_root (w_root),
        .o_rem  ()
    );

    // sign line spans the dividend register plus every divider stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                r_dvd[l] <= (qbv_pkg::DVD_W'(r_mline[MLEN-1][l]) << qbv_pkg::QB)
                          + qbv_pkg::DVD_W'(w_root >> 1);
            end
            r_dn       <= w_root;
            r_sline[0] <= {r_nline[MLEN-1], w_root == '0};
            for (int s = 1; s < SLEN; s++) begin
                r_sline[s] <= r_sline[s-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        qbv_div u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_dvd (r_dvd[g]),
            .i_dsr (r_dn),
            .o_quo (w_quo[g])
        );
    end

    assign w_sgn = r_sline[SLEN-1];

    // zero vector reads as all zeros, the quotient is junk there
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 3; l++) begin
                if (w_sgn[0]) begin
                    r_unit[l] <= '0;
                end else if (w_sgn[l+1]) begin
                    r_unit[l] <= -$signed(qbv_pkg::VEC_W'(w_quo[l]));
                end else begin
                    r_unit[l] <= $signed(qbv_pkg::VEC_W'(w_quo[l]));
                end
            end
            r_zero <= w_sgn[0];
        end
    end

    assign o_unit = r_unit;
    assign o_zero = r_zero;

endmodule
